@@ rtl/lct_pkg.sv @@
// Shared definitions for the load-cell tension conditioner: field widths,
// register reset values, result status codes and controller/datapath structs.
// No dependencies.
package lct_pkg;

  localparam int unsigned RAW_W      = 24;
  localparam int unsigned FORCE_W    = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned DEADBAND_W = 24;
  localparam int unsigned INV_W      = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned MAX_TARE_SAMPLES = 255;

  localparam logic [SCALE_W-1:0]    SCALE_RESET     = 24'd95622;
  localparam logic                  DIRECTION_RESET = 1'b0;
  localparam logic [ALPHA_W-1:0]    ALPHA_RESET     = 17'd13107;
  localparam logic [DEADBAND_W-1:0] DEADBAND_RESET  = 24'd1311;
  localparam logic [INV_W-1:0]      INV_GEOM_RESET  = 18'd33921;

  // Filter weight of one in Q1.16.
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh800000;
  localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;

  typedef enum logic [1:0] {
    STAT_MEASURED  = 2'd0,
    STAT_IGNORED   = 2'd1,
    STAT_TARE_ACC  = 2'd2,
    STAT_TARE_DONE = 2'd3
  } lct_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE     = 3'd0,
    CFG_DIRECTION = 3'd1,
    CFG_ALPHA     = 3'd2,
    CFG_DEADBAND  = 3'd3,
    CFG_INV_GEOM  = 3'd4
  } lct_cfg_idx_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SCALE   = 2'd0,
    MUL_NEW     = 2'd1,
    MUL_OLD     = 2'd2,
    MUL_TENSION = 2'd3
  } lct_mul_sel_t;

  // Where a newly presented request goes once it is captured.
  typedef enum logic [1:0] {
    ROUTE_FINISH   = 2'd0,
    ROUTE_TARE_DIV = 2'd1,
    ROUTE_MEASURE  = 2'd2
  } lct_route_t;

  typedef struct packed {
    logic         capture;
    logic         mul_en;
    lct_mul_sel_t mul_sel;
    logic         acc_load;
    logic         acc_add;
    logic         raw_en;
    logic         filt_en;
    logic         db_en;
    logic         ten_en;
    logic         div_load;
    logic         div_step;
    logic         tare_set;
    logic         out_load;
  } lct_cmd_t;

  typedef struct packed {
    lct_route_t route;
    logic       seeded;
    logic       div_last;
    logic       out_full;
  } lct_stat_t;

endpackage

@@ rtl/lct_if.sv @@
// Valid/ready channel interfaces for the request, result and configuration
// write channels of the load-cell tension conditioner. Depends on lct_pkg.
interface lct_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  req_type;
  logic signed [lct_pkg::RAW_W-1:0]      raw_sample;
  logic                                  tare_last;

  modport source (output valid, req_type, raw_sample, tare_last, input ready);
  modport sink (input valid, req_type, raw_sample, tare_last, output ready);
endinterface

interface lct_out_if;
  logic                                  valid;
  logic                                  ready;
  lct_pkg::lct_status_t                  status;
  logic signed [lct_pkg::RAW_W-1:0]      raw_echo;
  logic signed [lct_pkg::FORCE_W-1:0]    force_unfiltered;
  logic signed [lct_pkg::FORCE_W-1:0]    force_smoothed;
  logic signed [lct_pkg::FORCE_W-1:0]    tether_tension;
  logic                                  full_scale;

  modport source (output valid, status, raw_echo, force_unfiltered, force_smoothed,
                  tether_tension, full_scale, input ready);
  modport sink (input valid, status, raw_echo, force_unfiltered, force_smoothed,
                tether_tension, full_scale, output ready);
endinterface

interface lct_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [lct_pkg::CFG_IDX_W-1:0]         index;
  logic [lct_pkg::CFG_DATA_W-1:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/lct_ctrl.sv @@
// Sequencing state machine for the load-cell tension conditioner. Issues
// one command word per cycle to the datapath. Depends on lct_pkg.
module lct_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lct_pkg::lct_stat_t stat,
  output lct_pkg::lct_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV,
    S_TARE_SET,
    S_MUL_SCALE,
    S_ROUND_RAW,
    S_MUL_NEW,
    S_MUL_OLD,
    S_ACC_SUM,
    S_FILTER,
    S_DEADBAND,
    S_MUL_TEN,
    S_ROUND_TEN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (stat.route)
            lct_pkg::ROUTE_TARE_DIV: state_nxt = S_DIV_LOAD;
            lct_pkg::ROUTE_MEASURE:  state_nxt = S_MUL_SCALE;
            default:                 state_nxt = S_FINISH;
          endcase
        end
      end
      S_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_TARE_SET;
        end
      end
      S_TARE_SET: begin
        cmd.tare_set = 1'b1;
        state_nxt    = S_FINISH;
      end
      S_MUL_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lct_pkg::MUL_SCALE;
        state_nxt   = S_ROUND_RAW;
      end
      S_ROUND_RAW: begin
        cmd.raw_en = 1'b1;
        // The first sample after a tare seeds the filter and skips the blend.
        state_nxt  = stat.seeded ? S_MUL_NEW : S_DEADBAND;
      end
      S_MUL_NEW: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lct_pkg::MUL_NEW;
        state_nxt   = S_MUL_OLD;
      end
      S_MUL_OLD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = lct_pkg::MUL_OLD;
        cmd.acc_load = 1'b1;
        state_nxt    = S_ACC_SUM;
      end
      S_ACC_SUM: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_FILTER;
      end
      S_FILTER: begin
        cmd.filt_en = 1'b1;
        state_nxt   = S_DEADBAND;
      end
      S_DEADBAND: begin
        cmd.db_en = 1'b1;
        state_nxt = S_MUL_TEN;
      end
      S_MUL_TEN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lct_pkg::MUL_TENSION;
        state_nxt   = S_ROUND_TEN;
      end
      S_ROUND_TEN: begin
        cmd.ten_en = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/lct_dp.sv @@
// Datapath of the load-cell tension conditioner: configuration registers,
// tare accumulator and radix-2 divider, shared multiplier, filter and result
// register. Driven by lct_ctrl. Depends on lct_pkg and lct_if.
module lct_dp #(
  parameter int unsigned MaxTareSamples = lct_pkg::MAX_TARE_SAMPLES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_req_type,
  input  logic signed [lct_pkg::RAW_W-1:0]      in_raw_sample,
  input  logic                                  in_tare_last,
  input  logic                                  cfg_we,
  input  logic [lct_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lct_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  lct_pkg::lct_cmd_t                     cmd,
  output lct_pkg::lct_stat_t                    stat,
  lct_out_if.source                             out_res
);

  localparam int unsigned RawW    = lct_pkg::RAW_W;
  localparam int unsigned ForceW  = lct_pkg::FORCE_W;
  localparam int unsigned CntW    = $clog2(MaxTareSamples + 1);
  localparam int unsigned SumW    = RawW + CntW;
  localparam int unsigned MagW    = SumW - 1;
  localparam int unsigned DivCntW = $clog2(MagW);
  localparam int unsigned DiffW   = RawW + 1;
  localparam int unsigned OpBW    = lct_pkg::SCALE_W + 1;
  localparam int unsigned ProdW   = ForceW + OpBW;
  localparam int unsigned RndW    = ProdW - 16;
  localparam int unsigned DbW     = ForceW + 1;

  localparam logic [CntW-1:0]    MaxCnt  = CntW'(MaxTareSamples);
  localparam logic [DivCntW-1:0] LastDiv = DivCntW'(MagW - 1);

  // Divide by 2^16, rounding to nearest with halves away from zero.
  function automatic logic signed [RndW-1:0] round16(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] t;
    t = v + (v[ProdW-1] ? ProdW'(32767) : ProdW'(32768));
    return t[ProdW-1:16];
  endfunction

  function automatic logic signed [ForceW-1:0] sat32(input logic signed [RndW-1:0] v);
    logic signed [ForceW-1:0] r;
    if (v[RndW-1:ForceW-1] == {(RndW - ForceW + 1){v[RndW-1]}}) begin
      r = v[ForceW-1:0];
    end else if (v[RndW-1]) begin
      r = {1'b1, {(ForceW - 1){1'b0}}};
    end else begin
      r = {1'b0, {(ForceW - 1){1'b1}}};
    end
    return r;
  endfunction

  // Configuration registers.
  logic [lct_pkg::SCALE_W-1:0]    scale_r;
  logic                           dir_r;
  logic [lct_pkg::ALPHA_W-1:0]    alpha_r;
  logic [lct_pkg::DEADBAND_W-1:0] deadband_r;
  logic [lct_pkg::INV_W-1:0]      inv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r    <= lct_pkg::SCALE_RESET;
      dir_r      <= lct_pkg::DIRECTION_RESET;
      alpha_r    <= lct_pkg::ALPHA_RESET;
      deadband_r <= lct_pkg::DEADBAND_RESET;
      inv_r      <= lct_pkg::INV_GEOM_RESET;
    end else if (cfg_we) begin
      unique case (lct_pkg::lct_cfg_idx_t'(cfg_index))
        lct_pkg::CFG_SCALE:     scale_r    <= cfg_data[lct_pkg::SCALE_W-1:0];
        lct_pkg::CFG_DIRECTION: dir_r      <= cfg_data[0];
        lct_pkg::CFG_ALPHA:     alpha_r    <= cfg_data[lct_pkg::ALPHA_W-1:0];
        lct_pkg::CFG_DEADBAND:  deadband_r <= cfg_data[lct_pkg::DEADBAND_W-1:0];
        lct_pkg::CFG_INV_GEOM:  inv_r      <= cfg_data[lct_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Persistent state.
  logic signed [RawW-1:0]   offset_r;
  logic                     tared_r;
  logic                     seeded_r;
  logic signed [ForceW-1:0] filter_r;
  logic signed [SumW-1:0]   tare_sum_r;
  logic [CntW-1:0]          tare_cnt_r;
  logic                     out_valid_r;

  // Per-request working registers.
  lct_pkg::lct_status_t     status_r;
  logic signed [RawW-1:0]   raw_r;
  logic                     full_r;
  logic signed [DiffW-1:0]  diff_r;
  logic signed [ProdW-1:0]  prod_r;
  logic signed [ProdW-1:0]  acc_r;
  logic signed [ForceW-1:0] f_raw_r;
  logic signed [ForceW-1:0] smooth_r;
  logic signed [ForceW-1:0] tension_r;
  logic [MagW-1:0]          q_r;
  logic [CntW-1:0]          rem_r;
  logic                     neg_r;
  logic [DivCntW-1:0]       div_cnt_r;

  // Result register.
  lct_pkg::lct_status_t     out_status_r;
  logic signed [RawW-1:0]   out_raw_r;
  logic signed [ForceW-1:0] out_fu_r;
  logic signed [ForceW-1:0] out_fs_r;
  logic signed [ForceW-1:0] out_tt_r;
  logic                     out_full_r;

  // Capture-side logic.
  logic signed [SumW-1:0]  raw_ext;
  logic signed [DiffW-1:0] raw25;
  logic signed [DiffW-1:0] off25;
  logic                    tare_room;
  lct_pkg::lct_status_t    status_nxt;
  lct_pkg::lct_route_t     route_nxt;

  assign raw_ext   = SumW'(in_raw_sample);
  assign raw25     = DiffW'(in_raw_sample);
  assign off25     = DiffW'(offset_r);
  assign tare_room = (tare_cnt_r < MaxCnt);

  always_comb begin
    if (in_req_type) begin
      status_nxt = in_tare_last ? lct_pkg::STAT_TARE_DONE : lct_pkg::STAT_TARE_ACC;
      route_nxt  = in_tare_last ? lct_pkg::ROUTE_TARE_DIV : lct_pkg::ROUTE_FINISH;
    end else if (tared_r) begin
      status_nxt = lct_pkg::STAT_MEASURED;
      route_nxt  = lct_pkg::ROUTE_MEASURE;
    end else begin
      status_nxt = lct_pkg::STAT_IGNORED;
      route_nxt  = lct_pkg::ROUTE_FINISH;
    end
  end

  assign stat.route    = route_nxt;
  assign stat.seeded   = seeded_r;
  assign stat.div_last = (div_cnt_r == LastDiv);
  assign stat.out_full = out_valid_r & ~out_res.ready;

  // Shared multiplier.
  logic [lct_pkg::ALPHA_W-1:0] alpha_eff;
  logic [lct_pkg::ALPHA_W-1:0] alpha_rest;
  logic signed [ForceW-1:0]    op_a;
  logic signed [OpBW-1:0]      op_b;
  logic signed [ProdW-1:0]     mul_p;

  assign alpha_eff  = alpha_r[lct_pkg::ALPHA_W-1] ? lct_pkg::ALPHA_ONE : alpha_r;
  assign alpha_rest = lct_pkg::ALPHA_ONE - alpha_eff;

  always_comb begin
    unique case (cmd.mul_sel)
      lct_pkg::MUL_SCALE: begin
        op_a = ForceW'(diff_r);
        op_b = {1'b0, scale_r};
      end
      lct_pkg::MUL_NEW: begin
        op_a = f_raw_r;
        op_b = {{(OpBW - lct_pkg::ALPHA_W){1'b0}}, alpha_eff};
      end
      lct_pkg::MUL_OLD: begin
        op_a = filter_r;
        op_b = {{(OpBW - lct_pkg::ALPHA_W){1'b0}}, alpha_rest};
      end
      default: begin
        op_a = smooth_r;
        op_b = {{(OpBW - lct_pkg::INV_W){1'b0}}, inv_r};
      end
    endcase
  end

  assign mul_p = ProdW'(op_a) * ProdW'(op_b);

  logic signed [ForceW-1:0] raw_sat;
  logic signed [RndW-1:0]   filt_rnd;
  logic signed [ForceW-1:0] ten_sat;

  assign raw_sat  = sat32(round16(prod_r));
  assign filt_rnd = round16(acc_r);
  assign ten_sat  = sat32(round16(prod_r));

  // Deadband window.
  logic signed [DbW-1:0] filt_ext;
  logic signed [DbW-1:0] db_pos;
  logic signed [DbW-1:0] db_neg;
  logic                  in_band;

  assign filt_ext = DbW'(filter_r);
  assign db_pos   = {{(DbW - lct_pkg::DEADBAND_W){1'b0}}, deadband_r};
  assign db_neg   = -db_pos;
  assign in_band  = (filt_ext < db_pos) && (filt_ext > db_neg);

  // Restoring divider, one quotient bit per cycle.
  logic [CntW:0]    rem_sh;
  logic [CntW:0]    rem_sub;
  logic             q_bit;
  logic [MagW-1:0]  q_signed;

  assign rem_sh   = {rem_r, q_r[MagW-1]};
  assign rem_sub  = rem_sh - {1'b0, tare_cnt_r};
  assign q_bit    = (rem_sh >= {1'b0, tare_cnt_r});
  assign q_signed = neg_r ? (~q_r + MagW'(1)) : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= '0;
      tared_r     <= 1'b0;
      seeded_r    <= 1'b0;
      filter_r    <= '0;
      tare_sum_r  <= '0;
      tare_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.capture && in_req_type && tare_room) begin
        tare_sum_r <= tare_sum_r + raw_ext;
        tare_cnt_r <= tare_cnt_r + CntW'(1);
      end
      if (cmd.raw_en && !seeded_r) begin
        filter_r <= raw_sat;
        seeded_r <= 1'b1;
      end
      if (cmd.filt_en) begin
        filter_r <= filt_rnd[ForceW-1:0];
      end
      if (cmd.tare_set) begin
        offset_r   <= q_signed[RawW-1:0];
        tared_r    <= 1'b1;
        seeded_r   <= 1'b0;
        filter_r   <= '0;
        tare_sum_r <= '0;
        tare_cnt_r <= '0;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      status_r  <= status_nxt;
      raw_r     <= in_raw_sample;
      full_r    <= (in_raw_sample == lct_pkg::RAW_MIN) || (in_raw_sample == lct_pkg::RAW_MAX);
      diff_r    <= dir_r ? (off25 - raw25) : (raw25 - off25);
      f_raw_r   <= '0;
      smooth_r  <= '0;
      tension_r <= '0;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_p;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_r;
    end
    if (cmd.raw_en) begin
      f_raw_r <= raw_sat;
    end
    if (cmd.db_en) begin
      smooth_r <= in_band ? '0 : filter_r;
    end
    if (cmd.ten_en) begin
      tension_r <= ten_sat;
    end
    if (cmd.div_load) begin
      q_r       <= tare_sum_r[SumW-1] ? MagW'(-tare_sum_r) : MagW'(tare_sum_r);
      neg_r     <= tare_sum_r[SumW-1];
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[MagW-2:0], q_bit};
      rem_r     <= q_bit ? rem_sub[CntW-1:0] : rem_sh[CntW-1:0];
      div_cnt_r <= div_cnt_r + DivCntW'(1);
    end
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_raw_r    <= raw_r;
      out_fu_r     <= f_raw_r;
      out_fs_r     <= smooth_r;
      out_tt_r     <= tension_r;
      out_full_r   <= full_r;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.status           = out_status_r;
  assign out_res.raw_echo         = out_raw_r;
  assign out_res.force_unfiltered = out_fu_r;
  assign out_res.force_smoothed   = out_fs_r;
  assign out_res.tether_tension   = out_tt_r;
  assign out_res.full_scale       = out_full_r;

endmodule

@@ rtl/load_cell_tension_conditioner.sv @@
// Load-cell tension conditioner, top level. Joins the sequencer (lct_ctrl)
// and the datapath (lct_dp). Depends on lct_pkg and lct_if.
//
// Usage: samples arrive on in_req (valid/ready), one request per sample,
// tagged tare or measurement. Each request gives exactly one result on
// out_res. Registers are written on cfg_wr, which is always ready; write
// them only while no request is in flight.
// Work per request, from acceptance to the next acceptance: a tare sample
//   (not last) or a measurement before taring is only captured and loaded;
//   a measurement runs the full chain, less the filter blend for the first
//   one after a tare; the last tare sample adds the radix-2 offset divider.
// Measurements share one 32x25 multiplier over four passes, less the blend
// passes for the first one after a tare. A result is valid the cycle after
// its load into the result register.
// Reset (rst_n low, synchronous) restores register defaults, clears the
// tare state and the filter and empties the result register.
// When the receiver stalls, the result is held in the output register; the
// next request is still accepted and worked on, and only its final load
// into the output register waits for the earlier result to be taken.
module load_cell_tension_conditioner #(
  parameter int unsigned MaxTareSamples = lct_pkg::MAX_TARE_SAMPLES
) (
  input  logic      clk,
  input  logic      rst_n,
  lct_in_if.sink    in_req,
  lct_out_if.source out_res,
  lct_cfg_if.sink   cfg_wr
);

  lct_pkg::lct_cmd_t  cmd;
  lct_pkg::lct_stat_t stat;
  logic               ctrl_in_ready;

  assign in_req.ready = ctrl_in_ready;
  assign cfg_wr.ready = 1'b1;

  lct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (ctrl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lct_dp #(
    .MaxTareSamples (MaxTareSamples)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req.req_type),
    .in_raw_sample (in_req.raw_sample),
    .in_tare_last  (in_req.tare_last),
    .cfg_we        (cfg_wr.valid),
    .cfg_index     (cfg_wr.index),
    .cfg_data      (cfg_wr.data),
    .cmd           (cmd),
    .stat          (stat),
    .out_res       (out_res)
  );

endmodule

@@ rtl/lct_chk.sv @@
// Port-level checker for the load-cell tension conditioner and the bind
// that attaches it to the top level. Depends on lct_pkg.
module lct_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input lct_pkg::lct_status_t               out_status,
  input logic signed [lct_pkg::RAW_W-1:0]   out_raw_echo,
  input logic signed [lct_pkg::FORCE_W-1:0] out_force_unfiltered,
  input logic signed [lct_pkg::FORCE_W-1:0] out_force_smoothed,
  input logic signed [lct_pkg::FORCE_W-1:0] out_tether_tension,
  input logic                               out_full_scale
);

  // Requests are worked on one at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while the previous one is still in work");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_raw_echo) && $stable(out_tether_tension))
    else $error("stalled result changed or was dropped");

  // Only measured results carry force values.
  a_idle_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != lct_pkg::STAT_MEASURED) |->
      (out_force_unfiltered == '0) && (out_force_smoothed == '0) &&
      (out_tether_tension == '0))
    else $error("non-measured result carries a force value");

  a_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_full_scale == ((out_raw_echo == lct_pkg::RAW_MIN) ||
                                     (out_raw_echo == lct_pkg::RAW_MAX)))
    else $error("full-scale flag disagrees with the echoed sample");

endmodule

bind load_cell_tension_conditioner lct_chk u_lct_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_req.valid),
  .in_ready             (in_req.ready),
  .out_valid            (out_res.valid),
  .out_ready            (out_res.ready),
  .out_status           (out_res.status),
  .out_raw_echo         (out_res.raw_echo),
  .out_force_unfiltered (out_res.force_unfiltered),
  .out_force_smoothed   (out_res.force_smoothed),
  .out_tether_tension   (out_res.tether_tension),
  .out_full_scale       (out_res.full_scale)
);

@@ sim/tb.sv @@
// Self-checking bench for load_cell_tension_conditioner: tare and measurement
// requests are predicted in the bench and compared with every result.
// Depends on rtl/lct_pkg.sv, rtl/lct_if.sv and the top-level RTL.
module tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RawW        = lct_pkg::RAW_W;
  localparam int ForceW      = lct_pkg::FORCE_W;
  localparam int ScaleW      = lct_pkg::SCALE_W;
  localparam int AlphaW      = lct_pkg::ALPHA_W;
  localparam int DeadbandW   = lct_pkg::DEADBAND_W;
  localparam int InvW        = lct_pkg::INV_W;
  localparam int CfgDataW    = lct_pkg::CFG_DATA_W;

  typedef struct packed {
    logic                     is_tare;
    logic signed [RawW-1:0]   raw;
    logic                     last;
  } load_sample_t;

  typedef struct packed {
    lct_pkg::lct_status_t     status;
    logic signed [RawW-1:0]   raw_echo;
    logic signed [ForceW-1:0] force_unfiltered;
    logic signed [ForceW-1:0] force_smoothed;
    logic signed [ForceW-1:0] tether_tension;
    logic                     full_scale;
  } tension_result_t;

  logic clk;
  logic rst_n;

  lct_in_if  in_req ();
  lct_out_if out_res ();
  lct_cfg_if cfg_wr ();

  load_cell_tension_conditioner uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_wr  (cfg_wr)
  );

  // Register copies, updated when a write is accepted.
  logic [ScaleW-1:0]    scale_cfg    = lct_pkg::SCALE_RESET;
  logic                 dir_cfg      = lct_pkg::DIRECTION_RESET;
  logic [AlphaW-1:0]    alpha_cfg    = lct_pkg::ALPHA_RESET;
  logic [DeadbandW-1:0] deadband_cfg = lct_pkg::DEADBAND_RESET;
  logic [InvW-1:0]      inv_cfg      = lct_pkg::INV_GEOM_RESET;

  // Conditioner state as the bench sees it.
  logic signed [RawW-1:0] offset_q = '0;
  bit                     tared_q  = 1'b0;
  bit                     seeded_q = 1'b0;
  longint                 filt_q   = 0;
  longint                 tare_acc = 0;
  int                     tare_cnt = 0;

  load_sample_t    sample_backlog[$];
  tension_result_t tension_results_due[$];
  load_sample_t    next_sample;
  tension_result_t observed_result;
  tension_result_t wanted_result;

  logic signed [RawW-1:0] tare_center = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_queued = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_applied = 0;
  int stall_left = 0;
  int stall_mark = 500;
  int cycles_run = 0;
  int status_hits[4] = '{0, 0, 0, 0};

  function automatic longint round_q16(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 32768) >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic tension_result_t compute_tension_result(logic is_tare,
                                                             logic signed [RawW-1:0] raw,
                                                             logic last);
    tension_result_t res;
    longint diff;
    longint weight;
    longint smooth;
    longint mag;
    res.status           = lct_pkg::STAT_MEASURED;
    res.raw_echo         = raw;
    res.force_unfiltered = '0;
    res.force_smoothed   = '0;
    res.tether_tension   = '0;
    res.full_scale       = (raw == lct_pkg::RAW_MIN) || (raw == lct_pkg::RAW_MAX);
    if (is_tare) begin
      // Past the sample limit the run is no longer summed but still completes.
      if (tare_cnt < lct_pkg::MAX_TARE_SAMPLES) begin
        tare_acc = tare_acc + longint'(raw);
        tare_cnt = tare_cnt + 1;
      end
      if (last) begin
        if (tare_cnt != 0) offset_q = RawW'(tare_acc / longint'(tare_cnt));
        tared_q  = 1'b1;
        seeded_q = 1'b0;
        filt_q   = 0;
        tare_acc = 0;
        tare_cnt = 0;
        res.status = lct_pkg::STAT_TARE_DONE;
      end else begin
        res.status = lct_pkg::STAT_TARE_ACC;
      end
    end else if (!tared_q) begin
      res.status = lct_pkg::STAT_IGNORED;
    end else begin
      diff = longint'(raw) - longint'(offset_q);
      if (dir_cfg) diff = -diff;
      weight = (alpha_cfg > lct_pkg::ALPHA_ONE) ? 65536 : longint'(alpha_cfg);
      res.force_unfiltered = ForceW'(clamp32(round_q16(diff * longint'(scale_cfg))));
      if (!seeded_q) begin
        filt_q   = longint'(res.force_unfiltered);
        seeded_q = 1'b1;
      end else begin
        filt_q = round_q16(weight * longint'(res.force_unfiltered) +
                           (65536 - weight) * filt_q);
      end
      smooth = filt_q;
      mag = (smooth < 0) ? -smooth : smooth;
      if (mag < longint'(deadband_cfg)) smooth = 0;
      res.force_smoothed = ForceW'(smooth);
      res.tether_tension = ForceW'(clamp32(round_q16(smooth * longint'(inv_cfg))));
    end
    return res;
  endfunction

  function automatic logic signed [RawW-1:0] rand_raw();
    int pick;
    int t;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return lct_pkg::RAW_MIN;
      1: return lct_pkg::RAW_MAX;
      2, 3: begin
        t = int'($urandom_range(0, 2000)) - 1000;
        return t[RawW-1:0];
      end
      default: return RawW'($urandom());
    endcase
  endfunction

  function automatic logic signed [RawW-1:0] near_center();
    int t;
    t = int'(tare_center) + int'($urandom_range(0, 400)) - 200;
    return t[RawW-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d of %0d results", cycles_run,
               results_seen, items_queued);
      $display("Mismatches found");
      $finish;
    end
  end

  // Request driver: holds each request until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else begin
      if (in_req.valid && in_req.ready) begin
        tension_results_due.push_back(compute_tension_result(in_req.req_type,
                                                             in_req.raw_sample,
                                                             in_req.tare_last));
      end
      if (!(in_req.valid && !in_req.ready)) begin
        if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_sample = sample_backlog.pop_front();
          in_req.valid      <= 1'b1;
          in_req.req_type   <= next_sample.is_tare;
          in_req.raw_sample <= next_sample.raw;
          in_req.tare_last  <= next_sample.last;
        end else begin
          in_req.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off: from five hundred answered requests on, and every
  // thousand after that, results are refused until stall_left counts down,
  // while the driver keeps offering; the block backs up and stalls in_req.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_left == 0 && results_seen >= stall_mark) begin
      stall_left <= 300;
      stall_mark <= stall_mark + 1000;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_res.ready <= 1'b0;
    end else begin
      if (out_res.valid && out_res.ready) begin
        results_seen++;
        observed_result.status           = out_res.status;
        observed_result.raw_echo         = out_res.raw_echo;
        observed_result.force_unfiltered = out_res.force_unfiltered;
        observed_result.force_smoothed   = out_res.force_smoothed;
        observed_result.tether_tension   = out_res.tether_tension;
        observed_result.full_scale       = out_res.full_scale;
        if (tension_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result %0d arrived with no request outstanding", results_seen);
        end else begin
          wanted_result = tension_results_due.pop_front();
          status_hits[wanted_result.status]++;
          if (observed_result !== wanted_result) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Result %0d expected: status %0d raw %0d unf %0d smooth %0d ten %0d fs %0b",
                       results_seen, wanted_result.status, wanted_result.raw_echo,
                       wanted_result.force_unfiltered, wanted_result.force_smoothed,
                       wanted_result.tether_tension, wanted_result.full_scale);
              $display("Result %0d actual:   status %0d raw %0d unf %0d smooth %0d ten %0d fs %0b",
                       results_seen, observed_result.status, observed_result.raw_echo,
                       observed_result.force_unfiltered, observed_result.force_smoothed,
                       observed_result.tether_tension, observed_result.full_scale);
            end
          end
        end
      end
      if (stall_left > 0) begin
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic push_sample(logic is_tare, logic signed [RawW-1:0] raw, logic last);
    load_sample_t s;
    s.is_tare = is_tare;
    s.raw     = raw;
    s.last    = last;
    sample_backlog.push_back(s);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (results_seen != items_queued) @(posedge clk);
  endtask

  task automatic reg_write(lct_pkg::lct_cfg_idx_t idx, logic [CfgDataW-1:0] value);
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    cfg_wr.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    case (idx)
      lct_pkg::CFG_SCALE:     scale_cfg    = value[ScaleW-1:0];
      lct_pkg::CFG_DIRECTION: dir_cfg      = value[0];
      lct_pkg::CFG_ALPHA:     alpha_cfg    = value[AlphaW-1:0];
      lct_pkg::CFG_DEADBAND:  deadband_cfg = value[DeadbandW-1:0];
      lct_pkg::CFG_INV_GEOM:  inv_cfg      = value[InvW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [ScaleW-1:0] scale, logic dir, logic [AlphaW-1:0] alpha,
                               logic [DeadbandW-1:0] deadband, logic [InvW-1:0] inv);
    wait_idle();
    reg_write(lct_pkg::CFG_SCALE, CfgDataW'(scale));
    reg_write(lct_pkg::CFG_DIRECTION, CfgDataW'(dir));
    reg_write(lct_pkg::CFG_ALPHA, CfgDataW'(alpha));
    reg_write(lct_pkg::CFG_DEADBAND, CfgDataW'(deadband));
    reg_write(lct_pkg::CFG_INV_GEOM, CfgDataW'(inv));
    cfg_wr.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic random_setting();
    logic [ScaleW-1:0]    scale;
    logic [AlphaW-1:0]    alpha;
    logic [DeadbandW-1:0] deadband;
    logic [InvW-1:0]      inv;
    scale    = $urandom_range(0, 1) ? ScaleW'($urandom_range(1, 200000)) : ScaleW'($urandom());
    alpha    = $urandom_range(0, 3) != 0 ? AlphaW'($urandom_range(0, 65536)) :
                                           AlphaW'($urandom());
    deadband = $urandom_range(0, 1) ? DeadbandW'($urandom_range(0, 5000)) :
                                      DeadbandW'($urandom());
    inv      = InvW'($urandom());
    apply_setting(scale, 1'($urandom_range(0, 1)), alpha, deadband, inv);
  endtask

  // Mostly measurement bursts, near the tared level or random, between tare
  // runs, with some runs left open so that measurements see the old offset.
  task automatic run_segment(int count, int long_run);
    int n;
    int pick;
    int len;
    int i;
    n = 0;
    if (long_run > 0) begin
      tare_center = rand_raw();
      for (i = 0; i < long_run; i++) push_sample(1'b1, near_center(), i == long_run - 1);
    end
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 14) begin
        len = $urandom_range(1, 6);
        tare_center = rand_raw();
        for (i = 0; i < len; i++) push_sample(1'b1, near_center(), i == len - 1);
        n += len;
      end else if (pick < 17) begin
        push_sample(1'b1, rand_raw(), 1'b0);
        n++;
      end else begin
        len = $urandom_range(1, 10);
        for (i = 0; i < len; i++)
          push_sample(1'b0, $urandom_range(0, 1) ? near_center() : rand_raw(),
                      1'($urandom_range(0, 1)));
        n += len;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_req.valid      = 1'b0;
    in_req.req_type   = 1'b0;
    in_req.raw_sample = '0;
    in_req.tare_last  = 1'b0;
    out_res.ready     = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = '0;
    cfg_wr.data       = '0;
    send_idle_pct     = 26;
    recv_idle_pct     = 63;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset register values.
    push_sample(1'b0, lct_pkg::RAW_MAX, 1'b0);
    push_sample(1'b0, lct_pkg::RAW_MIN, 1'b1);
    push_sample(1'b1, 24'sd1000, 1'b1);
    push_sample(1'b0, 24'sd1000, 1'b0);
    push_sample(1'b0, lct_pkg::RAW_MAX, 1'b0);
    push_sample(1'b0, lct_pkg::RAW_MIN, 1'b0);
    push_sample(1'b0, 24'sd0, 1'b0);
    push_sample(1'b0, -24'sd1, 1'b1);
    // A new tare run while tared: the old offset stays in use until it ends,
    // and the negative sum is truncated toward zero.
    push_sample(1'b1, -24'sd5, 1'b0);
    push_sample(1'b0, 24'sd2000, 1'b0);
    push_sample(1'b1, -24'sd3, 1'b0);
    push_sample(1'b1, -24'sd3, 1'b1);
    push_sample(1'b0, 24'sd5, 1'b0);
    push_sample(1'b0, 24'sd12345, 1'b0);
    push_sample(1'b1, lct_pkg::RAW_MAX, 1'b0);
    push_sample(1'b1, lct_pkg::RAW_MAX, 1'b1);
    push_sample(1'b0, lct_pkg::RAW_MIN, 1'b0);
    push_sample(1'b0, lct_pkg::RAW_MAX, 1'b0);
    push_sample(1'b1, lct_pkg::RAW_MIN, 1'b1);
    push_sample(1'b0, lct_pkg::RAW_MAX, 1'b0);
    push_sample(1'b0, 24'sd0, 1'b0);

    random_setting();
    run_segment(200, 260);
    apply_setting('1, 1'b1, '1, '0, '1);
    run_segment(200, 0);

    send_idle_pct = 63;
    recv_idle_pct = 26;
    apply_setting('0, 1'b0, '0, '1, '0);
    run_segment(200, 255);
    apply_setting(24'd1, 1'b1, lct_pkg::ALPHA_ONE, 24'd1, 18'd1);
    run_segment(200, 0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_setting();
    run_segment(200, 256);
    apply_setting(lct_pkg::SCALE_RESET, lct_pkg::DIRECTION_RESET, lct_pkg::ALPHA_RESET,
                  lct_pkg::DEADBAND_RESET, lct_pkg::INV_GEOM_RESET);
    run_segment(200, 0);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Covered %0d measurements, %0d tare samples, %0d completed tare runs, %0d ignored",
             status_hits[lct_pkg::STAT_MEASURED], status_hits[lct_pkg::STAT_TARE_ACC],
             status_hits[lct_pkg::STAT_TARE_DONE], status_hits[lct_pkg::STAT_IGNORED]);
    $display("across %0d register settings; %0d mismatches, %0d results outstanding",
             settings_applied, mismatches, tension_results_due.size());
    if (mismatches == 0 && tension_results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ load_cell_tension_conditioner.f @@
rtl/lct_pkg.sv
rtl/lct_if.sv
rtl/lct_ctrl.sv
rtl/lct_dp.sv
rtl/load_cell_tension_conditioner.sv
rtl/lct_chk.sv
sim/tb.sv
